// ----- design/srpc_pkg.sv -----
// package for the stepper rate pulse controller: widths, codes, state and payload types
// no dependencies; used by the top level and by its checker
package srpc_pkg;

   localparam int MAX_PERIOD = 65536;
   localparam int PERIOD_MIN = 2;
   localparam int PERIOD_W   = $clog2(MAX_PERIOD + 1);
   localparam int COMPARE_W  = PERIOD_W - 1;

   localparam int RATE_IN_W  = 32;
   localparam int TIME_W     = 32;
   localparam int RATE_W     = 21;
   localparam int MAG_W      = 20;
   localparam int TICK_W     = 27;
   localparam int SETUP_W    = 16;
   localparam int OPCODE_W   = 2;

   // divider numerator: tick rate plus half the magnitude
   localparam int NUM_W      = TICK_W + 1;
   localparam int DIV_STEPS  = NUM_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam int REQ_DATA_W = RATE_IN_W + TIME_W;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_MAX_RATE   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MIN_RATE   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TICK_RATE  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_INVERT_DIR = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DIR_SETUP  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ENABLE_POL = 3'd5;

   localparam logic [MAG_W-1:0]   MAX_RATE_RST  = 20'd20000;
   localparam logic [MAG_W-1:0]   MIN_RATE_RST  = 20'd10;
   localparam logic [TICK_W-1:0]  TICK_RATE_RST = 27'd1000000;
   localparam logic [SETUP_W-1:0] DIR_SETUP_RST = 16'd5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SET_RATE = 2'd0,
      OP_ENABLE   = 2'd1,
      OP_DISABLE  = 2'd2,
      OP_STOP     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_POS  = 2'd1,
      DIR_NEG  = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLAMP,
      S_DECIDE,
      S_DIV,
      S_PERIOD,
      S_OUT
   } state_type;

   // request tdata, lowest bits first: rate, now_ms
   typedef struct packed {
      logic [TIME_W-1:0]    now_ms;
      logic [RATE_IN_W-1:0] rate;
   } req_payload_type;

   // response tdata, lowest bits at the bottom of the list
   typedef struct packed {
      logic [RATE_W-1:0]    applied_rate;
      logic [RATE_W-1:0]    requested_rate;
      logic                 enabled_flag;
      logic                 restart_counter;
      logic [COMPARE_W-1:0] compare_ticks;
      logic [PERIOD_W-1:0]  timer_period;
      logic                 pulse_on;
      logic                 dir_pin;
      logic                 enable_pin;
   } rsp_payload_type;

endpackage

// ----- design/stepper_rate_pulse_controller.sv -----
// stepper rate pulse controller top level: command decode, rate clamp, bit-serial divider
// depends on srpc_pkg
//
//   channel | role          | handshake                 | payload
//   --------+---------------+---------------------------+----------------------------------
//   req_    | command in    | tvalid / tready           | tuser opcode, tdata rate, now_ms
//   rsp_    | result out    | tvalid / tready           | tdata pins, period, flags, rates
//   csr_    | registers     | psel / penable / pwrite   | 32-bit data, register i at 4*i
//
// one command at a time; enable, disable, stop and set-rate commands that do not
// (re)start the pulse train go through the clamp, decide and output states
// a set rate that starts or retunes the pulses also runs the period clamp and the 28-step
// restoring divider that forms round(tick_rate / |rate|) one quotient bit per cycle
// req_tready is high only in idle; a held result in the output register stalls the
// controller before it loads the next one, never the transfer already in the register
// synchronous active-high reset puts the registers and the motor state to their defaults
module stepper_rate_pulse_controller (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [srpc_pkg::REQ_DATA_W-1:0] req_tdata,  // rate[31:0], now_ms[63:32]
   input  logic [srpc_pkg::OPCODE_W-1:0] req_tuser,    // opcode[1:0]
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // enable_pin[0], dir_pin[1], pulse_on[2], timer_period[19:3], compare_ticks[35:20],
   // restart_counter[36], enabled_flag[37], requested_rate[58:38], applied_rate[79:59]
   output logic [srpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [srpc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [srpc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [srpc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import srpc_pkg::*;

   // configuration registers
   logic [MAG_W-1:0]      max_rate_ff;
   logic [MAG_W-1:0]      min_rate_ff;
   logic [TICK_W-1:0]     tick_rate_ff;
   logic                  invert_dir_ff;
   logic [SETUP_W-1:0]    dir_setup_ff;
   logic                  enable_pol_ff;
   logic                  csr_write;
   logic [REG_IDX_W-1:0]  csr_index;

   // sequencer
   state_type             state_ff, state_in;
   logic                  out_load;

   // captured command
   req_payload_type       req_payload;
   opcode_type            op_ff, op_in;
   logic [RATE_IN_W-1:0]  rate_ff, rate_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic signed [RATE_W-1:0] clamp_ff, clamp_in;

   // motor state
   logic                  enabled_ff, enabled_in;
   dir_type               phys_ff, phys_in;
   logic [TIME_W-1:0]     ready_time_ff, ready_time_in;
   logic                  running_ff, running_in;
   logic signed [RATE_W-1:0] requested_ff, requested_in;
   logic signed [RATE_W-1:0] applied_ff, applied_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic                  restart_ff, restart_in;

   // divider
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [MAG_W-1:0]      den_ff, den_in;
   logic [MAG_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [MAG_W:0]        rem_shift;
   logic [MAG_W:0]        rem_diff;
   logic                  quo_bit;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   // decision terms
   logic signed [RATE_IN_W:0] rate_x;
   logic signed [RATE_IN_W:0] hi_x;
   logic signed [RATE_IN_W:0] lo_x;
   logic signed [RATE_IN_W:0] clamp_x;
   logic                  positive;
   dir_type               want_dir;
   logic [TIME_W-1:0]     elapsed;
   logic                  late;
   logic [RATE_W-1:0]     clamp_neg;
   logic [MAG_W-1:0]      mag;
   logic                  start_div;
   logic                  do_halt;

   // ------------------------------------------------------------------
   // register port, always ready, combinational read
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rate_ff   <= MAX_RATE_RST;
         min_rate_ff   <= MIN_RATE_RST;
         tick_rate_ff  <= TICK_RATE_RST;
         invert_dir_ff <= 1'b0;
         dir_setup_ff  <= DIR_SETUP_RST;
         enable_pol_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAX_RATE:   max_rate_ff   <= csr_pwdata[MAG_W-1:0];
            REG_MIN_RATE:   min_rate_ff   <= csr_pwdata[MAG_W-1:0];
            REG_TICK_RATE:  tick_rate_ff  <= csr_pwdata[TICK_W-1:0];
            REG_INVERT_DIR: invert_dir_ff <= csr_pwdata[0];
            REG_DIR_SETUP:  dir_setup_ff  <= csr_pwdata[SETUP_W-1:0];
            REG_ENABLE_POL: enable_pol_ff <= csr_pwdata[0];
            default: ;  // unmapped addresses are ignored
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MAX_RATE:   csr_prdata = CSR_DATA_W'(max_rate_ff);
         REG_MIN_RATE:   csr_prdata = CSR_DATA_W'(min_rate_ff);
         REG_TICK_RATE:  csr_prdata = CSR_DATA_W'(tick_rate_ff);
         REG_INVERT_DIR: csr_prdata = CSR_DATA_W'(invert_dir_ff);
         REG_DIR_SETUP:  csr_prdata = CSR_DATA_W'(dir_setup_ff);
         REG_ENABLE_POL: csr_prdata = CSR_DATA_W'(enable_pol_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // clamp and decision terms
   // ------------------------------------------------------------------
   assign req_payload = req_tdata;

   // max clamp first, then the dead band below min_rate
   always_comb begin
      rate_x = {rate_ff[RATE_IN_W-1], rate_ff};
      hi_x   = {{(RATE_IN_W + 1 - MAG_W){1'b0}}, max_rate_ff};
      lo_x   = {{(RATE_IN_W + 1 - MAG_W){1'b0}}, min_rate_ff};
      if (rate_x > hi_x) begin
         clamp_x = hi_x;
      end else if (rate_x < -hi_x) begin
         clamp_x = -hi_x;
      end else if (rate_x > -lo_x && rate_x < lo_x) begin
         clamp_x = '0;
      end else begin
         clamp_x = rate_x;
      end
   end

   assign positive  = (clamp_ff > 0) ^ invert_dir_ff;
   assign want_dir  = positive ? DIR_POS : DIR_NEG;
   // wrap-safe: still before the ready time when the difference is negative
   assign elapsed   = now_ff - ready_time_ff;
   assign late      = elapsed[TIME_W-1];
   assign clamp_neg = -clamp_ff;
   assign mag       = clamp_ff[RATE_W-1] ? clamp_neg[MAG_W-1:0] : clamp_ff[MAG_W-1:0];

   // a set rate that reaches the pulse timer needs a fresh period
   assign start_div = (op_ff == OP_SET_RATE) && enabled_ff && (clamp_ff != '0)
                      && (want_dir == phys_ff) && !late
                      && !(running_ff && (applied_ff == clamp_ff));

   // restoring divider step
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign quo_bit   = (rem_shift >= {1'b0, den_ff});

   // ------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_CLAMP;
         S_CLAMP:  state_in = S_DECIDE;
         S_DECIDE: state_in = start_div ? S_DIV : S_OUT;
         S_DIV:    if (cnt_ff == '0) state_in = S_PERIOD;
         S_PERIOD: state_in = S_OUT;
         S_OUT:    if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   // ------------------------------------------------------------------
   // datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      op_in         = op_ff;
      rate_in       = rate_ff;
      now_in        = now_ff;
      clamp_in      = clamp_ff;
      enabled_in    = enabled_ff;
      phys_in       = phys_ff;
      ready_time_in = ready_time_ff;
      running_in    = running_ff;
      requested_in  = requested_ff;
      applied_in    = applied_ff;
      period_in     = period_ff;
      restart_in    = restart_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      do_halt       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            op_in   = opcode_type'(req_tuser);
            rate_in = req_payload.rate;
            now_in  = req_payload.now_ms;
         end
         S_CLAMP: begin
            clamp_in = clamp_x[RATE_W-1:0];
         end
         S_DECIDE: begin
            restart_in = 1'b0;
            unique case (op_ff)
               OP_SET_RATE: begin
                  requested_in = clamp_ff;
                  if (!enabled_ff || clamp_ff == '0) begin
                     do_halt = 1'b1;
                  end else if (want_dir != phys_ff) begin
                     // direction change: stop and wait for the setup time
                     do_halt       = 1'b1;
                     phys_in       = want_dir;
                     ready_time_in = now_ff + TIME_W'(dir_setup_ff);
                  end else if (late) begin
                     do_halt = 1'b1;
                  end else if (start_div) begin
                     applied_in = clamp_ff;
                     if (!running_ff) begin
                        restart_in = 1'b1;
                        running_in = 1'b1;
                     end
                     num_in = NUM_W'(tick_rate_ff) + NUM_W'(mag[MAG_W-1:1]);
                     den_in = mag;
                     rem_in = '0;
                     cnt_in = CNT_W'(DIV_STEPS - 1);
                  end
               end
               OP_ENABLE: begin
                  do_halt    = 1'b1;
                  enabled_in = 1'b1;
               end
               OP_DISABLE: begin
                  requested_in = '0;
                  do_halt      = 1'b1;
                  enabled_in   = 1'b0;
               end
               OP_STOP: begin
                  requested_in = '0;
                  do_halt      = 1'b1;
               end
               default: ;
            endcase
            if (do_halt) begin
               running_in = 1'b0;
               applied_in = '0;
               period_in  = '0;
               restart_in = 1'b1;
            end
         end
         S_DIV: begin
            rem_in = quo_bit ? rem_diff[MAG_W-1:0] : rem_shift[MAG_W-1:0];
            num_in = {num_ff[NUM_W-2:0], quo_bit};
            cnt_in = cnt_ff - 1'b1;
         end
         S_PERIOD: begin
            // quotient sits in num_ff, clamp to the timer range
            if (num_ff < NUM_W'(PERIOD_MIN)) begin
               period_in = PERIOD_W'(PERIOD_MIN);
            end else if (num_ff > NUM_W'(MAX_PERIOD)) begin
               period_in = PERIOD_W'(MAX_PERIOD);
            end else begin
               period_in = num_ff[PERIOD_W-1:0];
            end
         end
         S_OUT: ;
         default: ;
      endcase
   end

   // result assembly into the output register
   always_comb begin
      rsp_data_in                 = rsp_data_ff;
      rsp_valid_in                = rsp_valid_ff & ~rsp_tready;
      if (out_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.enable_pin      = (enabled_ff == enable_pol_ff);
         rsp_data_in.dir_pin         = (phys_ff == DIR_POS);
         rsp_data_in.pulse_on        = running_ff;
         rsp_data_in.timer_period    = running_ff ? period_ff : '0;
         rsp_data_in.compare_ticks   = running_ff ? period_ff[PERIOD_W-1:1] : '0;
         rsp_data_in.restart_counter = restart_ff;
         rsp_data_in.enabled_flag    = enabled_ff;
         rsp_data_in.requested_rate  = requested_ff;
         rsp_data_in.applied_rate    = applied_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         enabled_ff    <= 1'b0;
         phys_ff       <= DIR_NONE;
         ready_time_ff <= '0;
         running_ff    <= 1'b0;
         requested_ff  <= '0;
         applied_ff    <= '0;
         period_ff     <= '0;
         restart_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         enabled_ff    <= enabled_in;
         phys_ff       <= phys_in;
         ready_time_ff <= ready_time_in;
         running_ff    <= running_in;
         requested_ff  <= requested_in;
         applied_ff    <= applied_in;
         period_ff     <= period_in;
         restart_ff    <= restart_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rate_ff     <= rate_in;
      now_ff      <= now_in;
      clamp_ff    <= clamp_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- design/srpc_checker.sv -----
// port-level checker for the stepper rate pulse controller, bound to the top level
// depends on srpc_pkg and stepper_rate_pulse_controller
module srpc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [srpc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import srpc_pkg::*;

   rsp_payload_type rsp;
   assign rsp = rsp_tdata;

   // one command in flight: no transfer right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while one is in flight");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // high time is half the period
   a_compare_half: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.compare_ticks == rsp.timer_period[PERIOD_W-1:1])
      else $error("compare ticks not half the period");

   // stopped pulses report no period and no applied rate
   a_stopped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.pulse_on |-> rsp.timer_period == '0 && rsp.applied_rate == '0)
      else $error("stopped pulse train with nonzero period or rate");

   // pulses run only on an enabled driver, within the timer range
   a_run_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.pulse_on |-> rsp.enabled_flag && rsp.timer_period >= PERIOD_MIN)
      else $error("pulses on while driver disabled or period out of range");

endmodule

bind stepper_rate_pulse_controller srpc_checker u_srpc_checker (.*);

// ----- bench/stepper_rate_pulse_controller_tb.sv -----
// self-checking bench for the stepper rate pulse controller: directed commands, register
// sweeps and random motion sequences checked against a cycle-free status predictor
// depends on srpc_pkg and stepper_rate_pulse_controller
`timescale 1ns / 1ps

module stepper_rate_pulse_controller_tb;

   import srpc_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // rate[31:0], now_ms[63:32]
   logic [OPCODE_W-1:0]   req_tuser;   // opcode[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // enable_pin, dir_pin, pulse_on, timer_period, compare_ticks, restart_counter,
   // enabled_flag, requested_rate, applied_rate
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   stepper_rate_pulse_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ---------------------------------------------------------------
   // predictor copy of the registers and the motor state
   // ---------------------------------------------------------------
   logic [MAG_W-1:0]   cfg_max_rate;
   logic [MAG_W-1:0]   cfg_min_rate;
   logic [TICK_W-1:0]  cfg_tick_rate;
   logic               cfg_invert_dir;
   logic [SETUP_W-1:0] cfg_dir_setup;
   logic               cfg_enable_high;

   logic                     drv_enabled;
   dir_type                  drv_dir;
   logic [TIME_W-1:0]        drv_ready_time;
   logic                     drv_running;
   logic signed [RATE_W-1:0] drv_requested;
   logic signed [RATE_W-1:0] drv_applied;
   logic [PERIOD_W-1:0]      drv_period;
   logic                     counter_cleared;

   // expected status words, oldest first
   rsp_payload_type pending_status[$];

   int mismatch_count;
   int result_count;

   // stimulus shaping
   logic              back_to_back;
   logic [TIME_W-1:0] wall_ms;
   int                last_rate;

   // checker scratch
   rsp_payload_type seen_status;
   rsp_payload_type want_status;
   string           wrong_fields;

   function automatic void reset_model();
      cfg_max_rate    = MAX_RATE_RST;
      cfg_min_rate    = MIN_RATE_RST;
      cfg_tick_rate   = TICK_RATE_RST;
      cfg_invert_dir  = 1'b0;
      cfg_dir_setup   = DIR_SETUP_RST;
      cfg_enable_high = 1'b1;
      drv_enabled     = 1'b0;
      drv_dir         = DIR_NONE;
      drv_ready_time  = '0;
      drv_running     = 1'b0;
      drv_requested   = '0;
      drv_applied     = '0;
      drv_period      = '0;
      counter_cleared = 1'b0;
   endfunction

   // stop action: pulses off and counter cleared
   function automatic void halt_pulse_train();
      drv_running     = 1'b0;
      drv_applied     = '0;
      drv_period      = '0;
      counter_cleared = 1'b1;
   endfunction

   // max clamp first, then the dead band below min_rate
   function automatic logic signed [RATE_W-1:0] clamp_speed(input logic [RATE_IN_W-1:0] raw);
      longint r;
      longint hi;
      longint lo;
      r  = $signed(raw);
      hi = cfg_max_rate;
      lo = cfg_min_rate;
      if (r > hi) return hi[RATE_W-1:0];
      if (r < -hi) begin
         r = -hi;
         return r[RATE_W-1:0];
      end
      if (r > -lo && r < lo) return '0;
      return r[RATE_W-1:0];
   endfunction

   // rounded tick_rate / |rate| held to 2..MAX_PERIOD
   function automatic logic [PERIOD_W-1:0] pulse_period(input logic signed [RATE_W-1:0] c);
      longint mag;
      longint tick;
      longint p;
      mag  = c;
      if (mag < 0) mag = -mag;
      tick = cfg_tick_rate;
      p    = (tick + mag / 2) / mag;
      if (p < PERIOD_MIN) p = PERIOD_MIN;
      if (p > MAX_PERIOD) p = MAX_PERIOD;
      return p[PERIOD_W-1:0];
   endfunction

   // one command through the controller, returns the status word it reports
   function automatic rsp_payload_type apply_command(input opcode_type op,
                                                     input logic [RATE_IN_W-1:0] rate_bits,
                                                     input logic [TIME_W-1:0] now);
      rsp_payload_type          s;
      logic signed [RATE_W-1:0] c;
      logic                     positive;
      dir_type                  want;
      logic [TIME_W-1:0]        since_ready;
      counter_cleared = 1'b0;
      case (op)
         OP_SET_RATE: begin
            c = clamp_speed(rate_bits);
            drv_requested = c;
            if (!drv_enabled || c == 0) begin
               halt_pulse_train();
            end else begin
               positive = (c > 0);
               if (cfg_invert_dir) positive = !positive;
               want = positive ? DIR_POS : DIR_NEG;
               since_ready = now - drv_ready_time;
               if (want != drv_dir) begin
                  // direction change: pulses off until the setup time has passed
                  halt_pulse_train();
                  drv_dir        = want;
                  drv_ready_time = now + {{(TIME_W-SETUP_W){1'b0}}, cfg_dir_setup};
               end else if (since_ready[TIME_W-1]) begin
                  halt_pulse_train();
               end else if (!(drv_running && drv_applied == c)) begin
                  drv_period = pulse_period(c);
                  if (!drv_running) begin
                     counter_cleared = 1'b1;
                     drv_running     = 1'b1;
                  end
                  drv_applied = c;
               end
            end
         end
         OP_ENABLE: begin
            halt_pulse_train();
            drv_enabled = 1'b1;
         end
         OP_DISABLE: begin
            drv_requested = '0;
            halt_pulse_train();
            drv_enabled = 1'b0;
         end
         default: begin
            drv_requested = '0;
            halt_pulse_train();
         end
      endcase
      s.enable_pin      = (drv_enabled == cfg_enable_high);
      s.dir_pin         = (drv_dir == DIR_POS);
      s.pulse_on        = drv_running;
      s.timer_period    = drv_running ? drv_period : '0;
      s.compare_ticks   = drv_running ? drv_period[PERIOD_W-1:1] : '0;
      s.restart_counter = counter_cleared;
      s.enabled_flag    = drv_enabled;
      s.requested_rate  = drv_requested;
      s.applied_rate    = drv_applied;
      return s;
   endfunction

   function automatic string show_status(input rsp_payload_type s);
      return $sformatf("en=%0d dir=%0d on=%0d per=%0d cmp=%0d rst=%0d enf=%0d req=%0d app=%0d",
                       s.enable_pin, s.dir_pin, s.pulse_on, s.timer_period, s.compare_ticks,
                       s.restart_counter, s.enabled_flag, $signed(s.requested_rate),
                       $signed(s.applied_rate));
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   // ---------------------------------------------------------------
   // result checker, sampled at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_status = rsp_tdata;
         result_count++;
         if (pending_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %0d: %s", result_count, show_status(seen_status));
         end else begin
            want_status  = pending_status.pop_front();
            wrong_fields = "";
            if (seen_status.enable_pin !== want_status.enable_pin)
               wrong_fields = {wrong_fields, " enable_pin"};
            if (seen_status.dir_pin !== want_status.dir_pin)
               wrong_fields = {wrong_fields, " dir_pin"};
            if (seen_status.pulse_on !== want_status.pulse_on)
               wrong_fields = {wrong_fields, " pulse_on"};
            if (seen_status.timer_period !== want_status.timer_period)
               wrong_fields = {wrong_fields, " timer_period"};
            if (seen_status.compare_ticks !== want_status.compare_ticks)
               wrong_fields = {wrong_fields, " compare_ticks"};
            if (seen_status.restart_counter !== want_status.restart_counter)
               wrong_fields = {wrong_fields, " restart_counter"};
            if (seen_status.enabled_flag !== want_status.enabled_flag)
               wrong_fields = {wrong_fields, " enabled_flag"};
            if (seen_status.requested_rate !== want_status.requested_rate)
               wrong_fields = {wrong_fields, " requested_rate"};
            if (seen_status.applied_rate !== want_status.applied_rate)
               wrong_fields = {wrong_fields, " applied_rate"};
            if (wrong_fields != "") begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch in result %0d:%s", result_count, wrong_fields);
                  $display("   expected %s", show_status(want_status));
                  $display("   actual   %s", show_status(seen_status));
               end
            end
         end
      end
   end

   // result-side stalls: runs of ready, random stalls, some long stall-free stretches
   initial begin
      int ready_run;
      int stall_len;
      rsp_tready = 1'b0;
      forever begin
         ready_run = $urandom_range(1, 12);
         if ($urandom_range(0, 9) == 0) ready_run = $urandom_range(50, 200);
         repeat (ready_run) begin
            @(negedge clock);
            rsp_tready = 1'b1;
         end
         stall_len = idle_cycles();
         repeat (stall_len) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------

   // one command transfer; valid stays high into the next call when there is no gap
   task automatic send_command(input opcode_type op, input logic [RATE_IN_W-1:0] rate_bits,
                               input logic [TIME_W-1:0] now);
      int              gap;
      req_payload_type payload;
      @(negedge clock);
      gap = back_to_back ? 0 : idle_cycles();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      payload.rate   = rate_bits;
      payload.now_ms = now;
      req_tdata  = payload;
      req_tuser  = op;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_status.push_back(apply_command(op, rate_bits, now));
   endtask

   // drop valid and wait until every expected status word is back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   // setup then access phase; register taken at the edge with pready high
   task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_MAX_RATE:   cfg_max_rate    = value[MAG_W-1:0];
         REG_MIN_RATE:   cfg_min_rate    = value[MAG_W-1:0];
         REG_TICK_RATE:  cfg_tick_rate   = value[TICK_W-1:0];
         REG_INVERT_DIR: cfg_invert_dir  = value[0];
         REG_DIR_SETUP:  cfg_dir_setup   = value[SETUP_W-1:0];
         REG_ENABLE_POL: cfg_enable_high = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_config(input int max_rate, input int min_rate, input int tick_rate,
                             input int invert, input int setup_ms, input int active_high);
      write_register(REG_MAX_RATE, max_rate);
      write_register(REG_MIN_RATE, min_rate);
      write_register(REG_TICK_RATE, tick_rate);
      write_register(REG_INVERT_DIR, invert);
      write_register(REG_DIR_SETUP, setup_ms);
      write_register(REG_ENABLE_POL, active_high);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // command walk on reset settings: setup hold, start, retune, clamps, wrap of time
   task automatic test_directed();
      send_command(OP_SET_RATE, 1000, 0);              // disabled: request only
      send_command(OP_ENABLE, 32'hFFFF_FFFF, 0);
      send_command(OP_SET_RATE, 1000, 100);            // first direction, hold 5 ms
      send_command(OP_SET_RATE, 1000, 103);            // still inside setup time
      send_command(OP_SET_RATE, 1000, 105);            // fresh start
      send_command(OP_SET_RATE, 1000, 106);            // same rate, nothing changes
      send_command(OP_SET_RATE, 2000, 107);            // retune, counter kept
      send_command(OP_SET_RATE, 9, 108);               // below min_rate
      send_command(OP_SET_RATE, -9, 109);
      send_command(OP_SET_RATE, 32'h7FFF_FFFF, 110);   // clamps to +max
      send_command(OP_SET_RATE, 32'h8000_0000, 111);   // clamps to -max, turns around
      send_command(OP_SET_RATE, -20000, 200);
      send_command(OP_SET_RATE, -10, 201);             // long period, clamped
      send_command(OP_STOP, 32'h0000_1234, 202);
      send_command(OP_SET_RATE, 0, 32'hFFFF_FFFF);
      send_command(OP_SET_RATE, 500, 32'hFFFF_FFFE);   // ready time wraps past zero
      send_command(OP_SET_RATE, 500, 32'hFFFF_FFFF);
      send_command(OP_SET_RATE, 500, 3);
      send_command(OP_DISABLE, 32'h8000_0000, 4);
      send_command(OP_SET_RATE, 500, 5);
   endtask

   // min above max, polarity low, zero setup, max of zero, tick rate of zero
   task automatic test_config_corners();
      drain_results();
      set_config(300, 1000, 1, 0, 0, 0);
      send_command(OP_ENABLE, 0, 50);
      send_command(OP_SET_RATE, 500, 50);
      send_command(OP_SET_RATE, 500, 50);
      send_command(OP_SET_RATE, 200, 51);
      drain_results();
      set_config(0, 10, TICK_RATE_RST, 0, 5, 1);
      send_command(OP_SET_RATE, 12345, 60);
      drain_results();
      set_config(1000, 1, 0, 1, 0, 1);
      send_command(OP_SET_RATE, -700, 70);
      send_command(OP_SET_RATE, -700, 71);
   endtask

   // random motion: mostly enable then set-rate runs with advancing time,
   // some noise in time, stops and disables
   task automatic run_motion_mix(input int count);
      opcode_type op;
      int         pick;
      int         lim;
      int         rate;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) back_to_back = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (!drv_enabled && pick < 60) op = OP_ENABLE;
         else if (pick < 4)             op = OP_DISABLE;
         else if (pick < 8)             op = OP_STOP;
         else if (pick < 11)            op = OP_ENABLE;
         else                           op = OP_SET_RATE;

         pick = $urandom_range(0, 99);
         if (pick < 50)      wall_ms = wall_ms + $urandom_range(0, 3);
         else if (pick < 80) wall_ms = wall_ms + $urandom_range(0, cfg_dir_setup + 2);
         else if (pick < 95) wall_ms = wall_ms + cfg_dir_setup + $urandom_range(0, 50);
         else if (pick < 98) wall_ms = $urandom;
         else                wall_ms = wall_ms - $urandom_range(1, cfg_dir_setup + 5);

         lim  = cfg_max_rate + cfg_max_rate / 4 + 2;
         pick = $urandom_range(0, 99);
         if (pick < 25)      rate = last_rate;
         else if (pick < 45) rate = last_rate + $urandom_range(0, 100) - 50;
         else if (pick < 65) rate = $urandom_range(0, lim);
         else if (pick < 75) rate = cfg_min_rate + $urandom_range(0, 2) - 1;
         else if (pick < 82) rate = cfg_max_rate + $urandom_range(0, 2) - 1;
         else if (pick < 90) rate = $urandom;
         else if (pick < 95) rate = -last_rate;
         else                rate = 0;
         // random sign on the fresh magnitudes
         if (pick >= 45 && pick < 82 && $urandom_range(0, 1) == 1) rate = -rate;

         if (op == OP_SET_RATE) begin
            last_rate = rate;
            send_command(op, rate, wall_ms);
         end else begin
            send_command(op, $urandom, wall_ms);
         end
      end
      back_to_back = 1'b0;
   endtask

   // register settings per phase: fixed extremes in phases 0 to 4 and 6, random ones in 5 and 7
   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         drain_results();
         case (phase)
            0: set_config(20000, 10, 1000000, 0, 5, 1);
            1: set_config(1000000, 1, 100000000, 1, 0, 0);
            2: set_config(20'hFFFFF, 20'hFFFFF, 27'h7FFFFFF, 0, 65535, 1);
            3: set_config(0, 0, 0, 1, 1, 0);
            4: set_config(300, 1000, 1, 0, 20, 1);
            6: set_config(1, 1, 0, 0, 3, 0);
            default: set_config($urandom_range(1, 1000000), $urandom_range(1, 1000),
                                $urandom_range(1, 100000000), $urandom_range(0, 1),
                                $urandom_range(0, 200), $urandom_range(0, 1));
         endcase
         wall_ms   = $urandom;
         last_rate = $urandom_range(1, cfg_max_rate + 1);
         run_motion_mix(228);
      end
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = OP_SET_RATE;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      result_count   = 0;
      back_to_back   = 1'b0;
      wall_ms        = '0;
      last_rate      = 0;
      reset_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_config_corners();
      test_random_phases();

      // let the last results come out, then idle before the final check
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // timeout, far beyond the slowest correct run
   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
